### src/burs_pkg.sv
// ----------------------------------------------------------------------------
// burs_pkg
// Shared types, widths and codes for the bounded undo/redo history stack.
// ----------------------------------------------------------------------------
package burs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int TOKEN_W     = 32;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int DEP_W       = 7;
    localparam int CMD_W       = 2;
    localparam int CODE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int EXT_W       = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_EXEC  = 2'd0,
        CMD_UNDO  = 2'd1,
        CMD_REDO  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CBFAIL  = 3'd4
    } t_status;

    typedef enum logic {
        REG_UNDO_CAP = 1'b0,
        REG_REDO_CAP = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        STK_NOP  = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2,
        STK_CLR  = 2'd3
    } t_stk_op;

    // per-cycle command to one stack
    typedef struct packed {
        t_stk_op           op;
        logic [FILL_W-1:0] cap;
    } t_stk_ctl;

    // shift control shared by every cell of a stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // capacity register clamped to the physical depth
    function automatic logic [FILL_W-1:0] cap_eff(input logic [CAP_W-1:0] c);
        logic [EXT_W-1:0] x;
        x = EXT_W'(c);
        if (x > EXT_W'(STACK_DEPTH)) begin
            x = EXT_W'(STACK_DEPTH);
        end
        return FILL_W'(x);
    endfunction

endpackage

### src/burs_if.sv
// ----------------------------------------------------------------------------
// burs_cmd_if / burs_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface burs_cmd_if import burs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [TOKEN_W-1:0] action_token;
    logic               action_valid;
    logic [CODE_W-1:0]  callback_code;

    modport source (output valid, cmd, action_token, action_valid, callback_code,
                    input ready);
    modport sink   (input valid, cmd, action_token, action_valid, callback_code,
                    output ready);
endinterface

interface burs_res_if import burs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   failure_code;
    logic [DEP_W-1:0]    undo_depth;
    logic [DEP_W-1:0]    redo_depth;
    logic [TOKEN_W-1:0]  undo_top;
    logic [TOKEN_W-1:0]  redo_top;

    modport source (output valid, status, failure_code, undo_depth, redo_depth,
                    undo_top, redo_top, input ready);
    modport sink   (input valid, status, failure_code, undo_depth, redo_depth,
                    undo_top, redo_top, output ready);
endinterface

### src/burs_cell.sv
// ----------------------------------------------------------------------------
// burs_cell
// One token slot of a shift-register stack; loads from the slot above on a
// push and from the slot below on a pop.
// ----------------------------------------------------------------------------
module burs_cell import burs_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [TOKEN_W-1:0] i_above,
    input  logic [TOKEN_W-1:0] i_below,
    output logic [TOKEN_W-1:0] o_q
);

    logic [TOKEN_W-1:0] r_q;
    logic [TOKEN_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_above;
        end else if (i_ctl.pop) begin
            n_q = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

### src/burs_stack.sv
// ----------------------------------------------------------------------------
// burs_stack
// Chain of token cells with the top at cell 0, plus the entry count.
// ----------------------------------------------------------------------------
module burs_stack import burs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stk_ctl           i_ctl,
    input  logic [TOKEN_W-1:0] i_din,
    output logic [FILL_W-1:0]  o_fill,
    output logic [TOKEN_W-1:0] o_top,
    output logic               o_over
);

    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    t_cell_ctl          w_cell_ctl;
    logic [TOKEN_W-1:0] w_q [STACK_DEPTH];

    assign w_cell_ctl.push = (i_ctl.op == STK_PUSH);
    assign w_cell_ctl.pop  = (i_ctl.op == STK_POP);

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [TOKEN_W-1:0] w_above;
        logic [TOKEN_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_din;
        end else begin : g_mid
            assign w_above = w_q[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_inner
            assign w_below = w_q[g+1];
        end

        burs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_q     (w_q[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        case (i_ctl.op)
            STK_PUSH: begin
                // at capacity the oldest entry falls out of the counted range
                if (r_fill < i_ctl.cap) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            STK_POP: begin
                n_fill = r_fill - FILL_W'(1);
            end
            STK_CLR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_fill = r_fill;
    assign o_top  = (r_fill != '0) ? w_q[0] : '0;
    assign o_over = (r_fill > i_ctl.cap);

endmodule

### src/bounded_undo_redo_stack.sv
// ----------------------------------------------------------------------------
// bounded_undo_redo_stack
// Flow: S_IDLE accepts a command word; S_WORK updates the stacks, popping one
// entry at a time while a push meets a stack filled above its capacity; S_EMIT
// loads the result once any earlier one is taken; a new word waits for S_IDLE.
// Reset: both stacks empty, both capacities 64; token cells are not cleared.
// ----------------------------------------------------------------------------
module bounded_undo_redo_stack import burs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    burs_cmd_if.sink          i_cmd,
    burs_res_if.source        o_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state;
    logic [CAP_W-1:0]   r_undo_cap;
    logic [CAP_W-1:0]   r_redo_cap;

    t_status            r_status;
    logic [CODE_W-1:0]  r_code;
    logic [TOKEN_W-1:0] r_tok;
    logic               r_dst_redo;
    logic               r_push;
    logic               r_clr_redo;
    logic               r_clr_all;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [CODE_W-1:0]  r_out_code;
    logic [DEP_W-1:0]   r_out_udep;
    logic [DEP_W-1:0]   r_out_rdep;
    logic [TOKEN_W-1:0] r_out_utop;
    logic [TOKEN_W-1:0] r_out_rtop;

    t_stk_ctl           w_uctl;
    t_stk_ctl           w_rctl;
    logic [TOKEN_W-1:0] w_din;
    logic [FILL_W-1:0]  w_ufill;
    logic [FILL_W-1:0]  w_rfill;
    logic [TOKEN_W-1:0] w_utop;
    logic [TOKEN_W-1:0] w_rtop;
    logic               w_uover;
    logic               w_rover;
    logic [FILL_W-1:0]  w_ucap;
    logic [FILL_W-1:0]  w_rcap;

    logic               w_accept;
    logic               w_load;
    logic               w_wr;
    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_dst_over;

    assign w_ucap   = cap_eff(r_undo_cap);
    assign w_rcap   = cap_eff(r_redo_cap);
    assign w_cmd    = t_cmd'(i_cmd.cmd);
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);
    assign w_dst_over = r_dst_redo ? w_rover : w_uover;
    assign i_cmd.ready = (r_state == S_IDLE);

    // ---------------- configuration port ----------------
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_comb begin
        case (t_reg_idx'(i_paddr[2]))
            REG_UNDO_CAP: o_prdata = DATA_W'(r_undo_cap);
            REG_REDO_CAP: o_prdata = DATA_W'(r_redo_cap);
            default:      o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undo_cap <= CAP_W'(64);
            r_redo_cap <= CAP_W'(64);
        end else if (w_wr) begin
            case (t_reg_idx'(i_paddr[2]))
                REG_UNDO_CAP: r_undo_cap <= i_pwdata[CAP_W-1:0];
                REG_REDO_CAP: r_redo_cap <= i_pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- status of an incoming word ----------------
    always_comb begin
        case (w_cmd)
            CMD_EXEC: begin
                if (!i_cmd.action_valid)            w_status = ST_INVALID;
                else if (i_cmd.callback_code != '0) w_status = ST_CBFAIL;
                else if (w_ucap == '0)              w_status = ST_FULL;
                else                                w_status = ST_OK;
            end
            CMD_UNDO: begin
                if (w_ufill == '0)                  w_status = ST_EMPTY;
                else if (i_cmd.callback_code != '0) w_status = ST_CBFAIL;
                else if (w_rcap == '0)              w_status = ST_FULL;
                else                                w_status = ST_OK;
            end
            CMD_REDO: begin
                if (w_rfill == '0)                  w_status = ST_EMPTY;
                else if (i_cmd.callback_code != '0) w_status = ST_CBFAIL;
                else if (w_ucap == '0)              w_status = ST_FULL;
                else                                w_status = ST_OK;
            end
            default: w_status = ST_OK;
        endcase
    end

    // ---------------- stack control ----------------
    always_comb begin
        w_uctl.op  = STK_NOP;
        w_uctl.cap = w_ucap;
        w_rctl.op  = STK_NOP;
        w_rctl.cap = w_rcap;
        w_din      = r_tok;
        if (r_state == S_IDLE && w_accept) begin
            // undo and redo take the token off the source right away
            if (w_cmd == CMD_UNDO && w_ufill != '0) w_uctl.op = STK_POP;
            if (w_cmd == CMD_REDO && w_rfill != '0) w_rctl.op = STK_POP;
        end else if (r_state == S_WORK) begin
            if (r_push && w_dst_over) begin
                // drop the newest entries above the lowered capacity
                if (r_dst_redo) w_rctl.op = STK_POP;
                else            w_uctl.op = STK_POP;
            end else begin
                if (r_push) begin
                    if (r_dst_redo) w_rctl.op = STK_PUSH;
                    else            w_uctl.op = STK_PUSH;
                end
                if (r_clr_redo || r_clr_all) w_rctl.op = STK_CLR;
                if (r_clr_all)               w_uctl.op = STK_CLR;
            end
        end
    end

    burs_stack u_undo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_uctl),
        .i_din   (w_din),
        .o_fill  (w_ufill),
        .o_top   (w_utop),
        .o_over  (w_uover)
    );

    burs_stack u_redo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rctl),
        .i_din   (w_din),
        .o_fill  (w_rfill),
        .o_top   (w_rtop),
        .o_over  (w_rover)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (w_accept) r_state <= S_WORK;
                S_WORK: if (!(r_push && w_dst_over)) r_state <= S_EMIT;
                S_EMIT: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_status   <= w_status;
            r_code     <= (w_status == ST_CBFAIL) ? i_cmd.callback_code : '0;
            r_clr_all  <= (w_cmd == CMD_CLEAR);
            r_clr_redo <= (w_cmd == CMD_EXEC) && (w_status == ST_OK);
            case (w_cmd)
                CMD_EXEC: begin
                    r_tok      <= i_cmd.action_token;
                    r_dst_redo <= 1'b0;
                    r_push     <= (w_status == ST_OK);
                end
                CMD_UNDO: begin
                    r_tok      <= w_utop;
                    // a failed callback puts the token back where it came from
                    r_dst_redo <= (w_status != ST_CBFAIL);
                    r_push     <= (w_status == ST_OK) ||
                                  ((w_status == ST_CBFAIL) && (w_ucap != '0));
                end
                CMD_REDO: begin
                    r_tok      <= w_rtop;
                    r_dst_redo <= (w_status == ST_CBFAIL);
                    r_push     <= (w_status == ST_OK) ||
                                  ((w_status == ST_CBFAIL) && (w_rcap != '0));
                end
                default: begin
                    r_tok      <= i_cmd.action_token;
                    r_dst_redo <= 1'b0;
                    r_push     <= 1'b0;
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_code   <= r_code;
            r_out_udep   <= DEP_W'(w_ufill);
            r_out_rdep   <= DEP_W'(w_rfill);
            r_out_utop   <= w_utop;
            r_out_rtop   <= w_rtop;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.failure_code = r_out_code;
    assign o_res.undo_depth   = r_out_udep;
    assign o_res.redo_depth   = r_out_rdep;
    assign o_res.undo_top     = r_out_utop;
    assign o_res.redo_top     = r_out_rtop;

`ifndef SYNTH
    a_accept_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WORK))
        else $error("accepted word did not start a stack update");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ufill <= FILL_W'(STACK_DEPTH)) && (w_rfill <= FILL_W'(STACK_DEPTH)))
        else $error("stack fill beyond physical depth");

    a_cbfail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_CBFAIL)) |-> (r_out_code != '0))
        else $error("callback failure reported without a code");
`endif

endmodule
